FILE: rtl/tfdd_pkg.sv
// Shared constants, types and footer table for the touch frame deframer and decoder.
`timescale 1ns / 1ps
`default_nettype none

package tfdd_pkg;

  localparam int BUF_DEPTH   = 256;
  localparam int HEAD_LEN    = 9;
  localparam int FOOT_LEN    = 6;
  localparam int FILL_W      = $clog2(BUF_DEPTH + 1);
  localparam int FIDX_W      = $clog2(FOOT_LEN);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_TOUCH = 3'd0;
  localparam logic [2:0] KIND_INFO  = 3'd1;
  localparam logic [2:0] KIND_CALIB = 3'd2;
  localparam logic [2:0] KIND_USB   = 3'd3;
  localparam logic [2:0] KIND_UNKN  = 3'd4;
  localparam logic [2:0] KIND_OVF   = 3'd5;

  localparam logic [7:0] TYPE_USB        = 8'h75;
  localparam logic [7:0] TYPE_INFO       = 8'h73;
  localparam logic [7:0] TYPE_CALIB      = 8'h6b;
  localparam logic [7:0] TYPE_IN_NONE    = 8'h00;
  localparam logic [7:0] TYPE_IN_LEFT    = 8'h01;
  localparam logic [7:0] TYPE_IN_RIGHT   = 8'h02;
  localparam logic [7:0] TYPE_OUT_NONE   = 8'h0a;
  localparam logic [7:0] TYPE_OUT_LEFT   = 8'h0b;
  localparam logic [7:0] TYPE_OUT_RIGHT  = 8'h0c;

  typedef struct packed {
    logic                         ovf;
    logic [HEAD_LEN-1:0][7:0]     head;
  } job_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         type_code;
    logic [31:0]        raw_x_word;
    logic [31:0]        raw_y_word;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic [1:0]         button;
    logic               outside_lcd;
  } res_t;

  // Footer "<END>\r", one byte per match position.
  function automatic logic [7:0] foot_byte(input logic [FIDX_W-1:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h3c;
      3'd1: b = 8'h45;
      3'd2: b = 8'h4e;
      3'd3: b = 8'h44;
      3'd4: b = 8'h3e;
      3'd5: b = 8'h0d;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tfdd_front.sv
// Front part: takes bytes, keeps the frame head, tracks the footer and issues decode jobs.
`timescale 1ns / 1ps
`default_nettype none

module tfdd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,
  input  wire logic           q_full,
  output logic                push,
  output tfdd_pkg::job_t      push_job
);

  logic [tfdd_pkg::HEAD_LEN-1:0][7:0] head_r, head_nxt;
  logic [tfdd_pkg::FILL_W-1:0]        fill_r, fill_nxt, fill_base;
  logic [tfdd_pkg::FIDX_W-1:0]        fidx_r, fidx_nxt, fidx_base;
  logic                               acc;
  logic                               ovf;
  logic                               done;

  assign in_tready = !q_full;

  always_comb begin
    acc       = in_tvalid && !q_full;
    ovf       = fill_r >= tfdd_pkg::FILL_W'(tfdd_pkg::BUF_DEPTH);
    fill_base = ovf ? '0 : fill_r;
    fidx_base = ovf ? '0 : fidx_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    fidx_nxt  = fidx_r;
    done      = 1'b0;
    if (acc) begin
      for (int i = 0; i < tfdd_pkg::HEAD_LEN; i++) begin
        if (fill_base == tfdd_pkg::FILL_W'(i)) begin
          head_nxt[i] = in_tdata;
        end
      end
      fill_nxt = fill_base + 1'b1;
      if (fidx_base < tfdd_pkg::FIDX_W'(tfdd_pkg::FOOT_LEN) &&
          in_tdata == tfdd_pkg::foot_byte(fidx_base)) begin
        if (fidx_base == tfdd_pkg::FIDX_W'(tfdd_pkg::FOOT_LEN - 1)) begin
          done     = 1'b1;
          fill_nxt = '0;
          fidx_nxt = '0;
        end else begin
          fidx_nxt = fidx_base + 1'b1;
        end
      end else begin
        fidx_nxt = '0;
      end
    end
    push          = acc && (ovf || done);
    push_job.ovf  = ovf;
    push_job.head = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      fidx_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      fidx_r <= fidx_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= tfdd_pkg::FILL_W'(tfdd_pkg::BUF_DEPTH))
    else $error("fill count beyond buffer depth");
  a_footer_restart: assert property (@(posedge clk) disable iff (!rst_n)
    push && !push_job.ovf |=> fill_r == '0 && fidx_r == '0)
    else $error("frame not restarted after footer");
`endif

endmodule

`default_nettype wire

FILE: rtl/tfdd_queue.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module tfdd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire tfdd_pkg::job_t  push_job,
  input  wire logic            pop,
  output logic                 q_full,
  output logic                 q_valid,
  output tfdd_pkg::job_t       q_job
);

  tfdd_pkg::job_t                entries_r [tfdd_pkg::QUEUE_DEPTH];
  logic [tfdd_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tfdd_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tfdd_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_pop;

  assign q_full  = count_r == tfdd_pkg::QCNT_W'(tfdd_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_job   = entries_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == tfdd_pkg::QPTR_W'(tfdd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tfdd_pkg::QPTR_W'(tfdd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("job pushed into a full queue");
`endif

endmodule

`default_nettype wire

FILE: rtl/tfdd_back.sv
// Back part: decodes queued jobs into result requests held in an output register.
`timescale 1ns / 1ps
`default_nettype none

module tfdd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire tfdd_pkg::job_t  q_job,
  output logic                 pop,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [143:0]         out_tdata,
  output logic [2:0]           out_tuser
);

  tfdd_pkg::res_t res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     t;
  logic [31:0]    xw;
  logic [31:0]    yw;

  function automatic logic [31:0] float_to_int(input logic [31:0] w);
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [7:0]  sh;
    logic [31:0] mag;
    logic [31:0] r;
    ex   = w[30:23];
    frac = w[22:0];
    sh   = ex - 8'd127;
    mag  = {8'h00, 1'b1, frac};
    if (ex == 8'hff && frac != '0) begin
      r = '0;
    end else if (ex < 8'd127) begin
      r = '0;
    end else if (sh >= 8'd31) begin
      r = w[31] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      if (sh >= 8'd23) begin
        mag = mag << (sh - 8'd23);
      end else begin
        mag = mag >> (8'd23 - sh);
      end
      r = w[31] ? (~mag + 32'd1) : mag;
    end
    return r;
  endfunction

  assign pop = q_valid && (!out_valid_r || out_tready);

  always_comb begin
    t  = q_job.head[8];
    xw = {q_job.head[0], q_job.head[1], q_job.head[2], q_job.head[3]};
    yw = {q_job.head[4], q_job.head[5], q_job.head[6], q_job.head[7]};
    res_nxt             = '0;
    res_nxt.type_code   = t;
    res_nxt.raw_x_word  = xw;
    res_nxt.raw_y_word  = yw;
    unique case (t) inside
      tfdd_pkg::TYPE_USB:   res_nxt.kind = tfdd_pkg::KIND_USB;
      tfdd_pkg::TYPE_INFO:  res_nxt.kind = tfdd_pkg::KIND_INFO;
      tfdd_pkg::TYPE_CALIB: res_nxt.kind = tfdd_pkg::KIND_CALIB;
      tfdd_pkg::TYPE_IN_NONE, tfdd_pkg::TYPE_IN_LEFT, tfdd_pkg::TYPE_IN_RIGHT,
      tfdd_pkg::TYPE_OUT_NONE, tfdd_pkg::TYPE_OUT_LEFT, tfdd_pkg::TYPE_OUT_RIGHT: begin
        res_nxt.kind        = tfdd_pkg::KIND_TOUCH;
        res_nxt.x_pos       = $signed(float_to_int(xw));
        res_nxt.y_pos       = $signed(float_to_int(yw));
        res_nxt.outside_lcd = t >= tfdd_pkg::TYPE_OUT_NONE;
        res_nxt.button      = (t >= tfdd_pkg::TYPE_OUT_NONE) ?
                              2'(t - tfdd_pkg::TYPE_OUT_NONE) : t[1:0];
      end
      default:              res_nxt.kind = tfdd_pkg::KIND_UNKN;
    endcase
    if (q_job.ovf) begin
      res_nxt      = '0;
      res_nxt.kind = tfdd_pkg::KIND_OVF;
    end
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {5'b0, res_r.outside_lcd, res_r.button, res_r.y_pos, res_r.x_pos,
                       res_r.raw_y_word, res_r.raw_x_word, res_r.type_code};

`ifndef NO_ASSERTIONS
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind == tfdd_pkg::KIND_OVF |->
      res_r.type_code == '0 && res_r.raw_x_word == '0 && res_r.raw_y_word == '0)
    else $error("overflow request carries frame data");
  a_nontouch_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.kind != tfdd_pkg::KIND_TOUCH |->
      res_r.x_pos == '0 && res_r.y_pos == '0 && res_r.button == '0 && !res_r.outside_lcd)
    else $error("non-touch request carries touch fields");
`endif

endmodule

`default_nettype wire

FILE: rtl/touch_frame_deframer_decoder_top.sv
// Top level of the touch frame deframer and decoder.
//
//   Channel  Dir  Handshake              Contents
//   in_      in   in_tvalid/in_tready    tdata: rx_byte
//   out_     out  out_tvalid/out_tready  tuser: result_kind; tdata: decoded frame fields
//
// One byte is taken every cycle while the job queue is not full; the frame or overflow
// result a byte causes goes through a queue entry write, then the decode into the output
// register, which waits while a held result is not taken. Both floats are decoded in the back part.
// Reset is synchronous and clears the frame head, counters, queue and output valid.
// in_tready falls only when the two-entry job queue is full, which needs out_tready low.
`timescale 1ns / 1ps
`default_nettype none

module touch_frame_deframer_decoder_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [7:0] type_code, [39:8] raw_x_word, [71:40] raw_y_word, [103:72] x_pos,
  // [135:104] y_pos, [137:136] button, [138] outside_lcd, [143:139] zero
  output logic [143:0]      out_tdata,
  output logic [2:0]        out_tuser   // [2:0] result_kind
);

  logic           push;
  tfdd_pkg::job_t push_job;
  logic           q_full;
  logic           q_valid;
  tfdd_pkg::job_t q_job;
  logic           pop;

  tfdd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  tfdd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  tfdd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire
